>>> src/utf8_validating_decoder_macros.svh
// assertion macros used by the decoder checker
`ifndef UTF8_VALIDATING_DECODER_MACROS_SVH
`define UTF8_VALIDATING_DECODER_MACROS_SVH

// combinational property checked at every clock edge outside reset
`define UTF8D_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define UTF8D_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UTF8D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/utf8d_pkg.sv
// types and constants of the utf-8 validating decoder
`default_nettype none

package utf8d_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 4;

    localparam int CHAR_W    = 21;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] ADDR_OUTPUT_UTF16 = 3'h0;

    localparam logic [CHAR_W-1:0] MIN_THREE_BYTE   = 21'h000800;
    localparam logic [CHAR_W-1:0] MIN_FOUR_BYTE    = 21'h010000;
    localparam logic [CHAR_W-1:0] MAX_CODE_POINT   = 21'h10FFFF;
    localparam logic [CHAR_W-1:0] SURROGATE_FIRST  = 21'h00D800;
    localparam logic [CHAR_W-1:0] SURROGATE_LAST   = 21'h00DFFF;
    localparam logic [CHAR_W-1:0] SUPP_BASE        = 21'h010000;
    localparam logic [CHAR_W-1:0] HIGH_SURR_BASE   = 21'h00D800;
    localparam logic [CHAR_W-1:0] LOW_SURR_BASE    = 21'h00DC00;

    typedef enum logic [2:0] {
        ERR_NONE          = 3'd0,
        ERR_BAD_LEAD      = 3'd1,
        ERR_OVERLONG_LEAD = 3'd2,
        ERR_TRUNCATED     = 3'd3,
        ERR_BAD_CONT      = 3'd4,
        ERR_BAD_CODE_PT   = 3'd5
    } err_code_t;

    // one decoded event from the front: a code point or an error
    typedef struct packed {
        logic [CHAR_W-1:0] char_value;
        logic              is_error;
        err_code_t         error_code;
        logic              text_done;
    } queue_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

>>> src/utf8d_queue.sv
// short queue of decoded events between front and back
`default_nettype none

module utf8d_queue #(
    parameter int DEPTH = utf8d_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire utf8d_pkg::queue_entry_t push_data,
    input  wire logic                    pop,
    output utf8d_pkg::queue_entry_t      head,
    output utf8d_pkg::queue_status_t     status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    utf8d_pkg::queue_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

>>> src/utf8d_front.sv
// byte classifier and sequence tracker: turns bytes into decoded events
`default_nettype none

module utf8d_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [7:0]               byte_value,
    input  wire logic                     end_of_text,
    input  wire logic                     byte_valid,
    output logic                          byte_ready,
    input  wire utf8d_pkg::queue_status_t q_status,
    output logic                          push,
    output utf8d_pkg::queue_entry_t       push_data
);

    logic [1:0]  rem_reg, rem_next;
    logic [1:0]  len_reg, len_next;
    logic [20:0] acc_reg, acc_next;
    logic        bad_reg, bad_next;
    logic        skip_reg, skip_next;

    logic                 accept;
    logic                 emit_char;
    logic                 emit_err;
    utf8d_pkg::err_code_t err_code;
    logic [20:0]          char_cp;
    logic                 bad_cont;
    logic [20:0]          acc_shift;
    logic [1:0]           rem_dec;
    logic                 cp_invalid;

    assign byte_ready = !q_status.full;
    assign accept     = byte_valid && byte_ready;

    assign bad_cont  = bad_reg || (byte_value[7:6] != 2'b10);
    assign acc_shift = {acc_reg[14:0], byte_value[5:0]};
    assign rem_dec   = rem_reg - 1'b1;

    // overlong, out of range or surrogate
    assign cp_invalid = ((len_reg == 2'd2) && (acc_shift < utf8d_pkg::MIN_THREE_BYTE))
                     || ((len_reg == 2'd3) && (acc_shift < utf8d_pkg::MIN_FOUR_BYTE))
                     || (acc_shift > utf8d_pkg::MAX_CODE_POINT)
                     || ((acc_shift >= utf8d_pkg::SURROGATE_FIRST)
                         && (acc_shift <= utf8d_pkg::SURROGATE_LAST));

    always_comb
    begin
        rem_next  = rem_reg;
        len_next  = len_reg;
        acc_next  = acc_reg;
        bad_next  = bad_reg;
        skip_next = skip_reg;
        emit_char = 1'b0;
        emit_err  = 1'b0;
        err_code  = utf8d_pkg::ERR_NONE;
        char_cp   = acc_shift;

        if (accept)
        begin
            if (skip_reg)
            begin
                if (end_of_text)
                begin
                    skip_next = 1'b0;
                    rem_next  = '0;
                    len_next  = '0;
                    acc_next  = '0;
                    bad_next  = 1'b0;
                end
            end
            else if (rem_reg == 2'd0)
            begin
                priority if (!byte_value[7])
                begin
                    emit_char = 1'b1;
                    char_cp   = {13'b0, byte_value};
                end
                else if (byte_value[7:5] == 3'b110)
                begin
                    if (byte_value[4:1] == 4'b0000)
                    begin
                        emit_err = 1'b1;
                        err_code = utf8d_pkg::ERR_OVERLONG_LEAD;
                    end
                    else if (end_of_text)
                    begin
                        emit_err = 1'b1;
                        err_code = utf8d_pkg::ERR_TRUNCATED;
                    end
                    else
                    begin
                        rem_next = 2'd1;
                        len_next = 2'd1;
                        acc_next = {16'b0, byte_value[4:0]};
                        bad_next = 1'b0;
                    end
                end
                else if (byte_value[7:4] == 4'b1110)
                begin
                    if (end_of_text)
                    begin
                        emit_err = 1'b1;
                        err_code = utf8d_pkg::ERR_TRUNCATED;
                    end
                    else
                    begin
                        rem_next = 2'd2;
                        len_next = 2'd2;
                        acc_next = {17'b0, byte_value[3:0]};
                        bad_next = 1'b0;
                    end
                end
                else if (byte_value[7:3] == 5'b11110)
                begin
                    if (end_of_text)
                    begin
                        emit_err = 1'b1;
                        err_code = utf8d_pkg::ERR_TRUNCATED;
                    end
                    else
                    begin
                        rem_next = 2'd3;
                        len_next = 2'd3;
                        acc_next = {18'b0, byte_value[2:0]};
                        bad_next = 1'b0;
                    end
                end
                else
                begin
                    emit_err = 1'b1;
                    err_code = utf8d_pkg::ERR_BAD_LEAD;
                end
            end
            else
            begin
                // continuation byte inside a sequence
                if (rem_dec != 2'd0)
                begin
                    if (end_of_text)
                    begin
                        emit_err = 1'b1;
                        err_code = utf8d_pkg::ERR_TRUNCATED;
                    end
                    else
                    begin
                        rem_next = rem_dec;
                        acc_next = acc_shift;
                        bad_next = bad_cont;
                    end
                end
                else if (bad_cont)
                begin
                    emit_err = 1'b1;
                    err_code = utf8d_pkg::ERR_BAD_CONT;
                end
                else if (cp_invalid)
                begin
                    emit_err = 1'b1;
                    err_code = utf8d_pkg::ERR_BAD_CODE_PT;
                end
                else
                begin
                    emit_char = 1'b1;
                end
            end

            if (emit_char || emit_err)
            begin
                rem_next = '0;
                len_next = '0;
                acc_next = '0;
                bad_next = 1'b0;
            end
            if (emit_err)
            begin
                skip_next = !end_of_text;
            end
        end
    end

    always_comb
    begin
        push                 = emit_char || emit_err;
        push_data.char_value = emit_err ? '0 : char_cp;
        push_data.is_error   = emit_err;
        push_data.error_code = err_code;
        push_data.text_done  = end_of_text;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            len_reg  <= '0;
            acc_reg  <= '0;
            bad_reg  <= 1'b0;
            skip_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            len_reg  <= len_next;
            acc_reg  <= acc_next;
            bad_reg  <= bad_next;
            skip_reg <= skip_next;
        end
    end

endmodule

`default_nettype wire

>>> src/utf8d_back.sv
// result stage: in utf-16 mode, splits supplementary code points into surrogate pairs
`default_nettype none

module utf8d_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     output_utf16,
    input  wire utf8d_pkg::queue_entry_t  head,
    input  wire utf8d_pkg::queue_status_t q_status,
    output logic                          pop,
    output logic                          result_valid,
    input  wire logic                     result_ready,
    output logic [20:0]                   char_value,
    output logic                          is_error,
    output logic [2:0]                    error_code,
    output logic                          last_of_run,
    output logic                          text_done
);

    logic        valid_reg, valid_next;
    logic        pair_reg, pair_next;
    logic [20:0] char_reg, char_next;
    logic [20:0] low_reg, low_next;
    logic        err_reg, err_next;
    logic [2:0]  code_reg, code_next;
    logic        last_reg, last_next;
    logic        done_reg, done_next;

    logic        load_ok;
    logic        supp;
    logic [20:0] offset;
    logic [20:0] high_unit;
    logic [20:0] low_unit;

    assign load_ok = !valid_reg || result_ready;
    assign pop     = load_ok && !pair_reg && !q_status.empty;

    assign supp      = output_utf16 && !head.is_error && (head.char_value[20:16] != 5'd0);
    assign offset    = head.char_value - utf8d_pkg::SUPP_BASE;
    assign high_unit = utf8d_pkg::HIGH_SURR_BASE + {11'b0, offset[19:10]};
    assign low_unit  = utf8d_pkg::LOW_SURR_BASE + {11'b0, offset[9:0]};

    always_comb
    begin
        valid_next = valid_reg;
        pair_next  = pair_reg;
        char_next  = char_reg;
        low_next   = low_reg;
        err_next   = err_reg;
        code_next  = code_reg;
        last_next  = last_reg;
        done_next  = done_reg;

        if (load_ok)
        begin
            priority if (pair_reg)
            begin
                // second half of a pair, same item so text_done is kept
                valid_next = 1'b1;
                pair_next  = 1'b0;
                char_next  = low_reg;
                last_next  = 1'b1;
            end
            else if (!q_status.empty)
            begin
                valid_next = 1'b1;
                pair_next  = supp;
                char_next  = supp ? high_unit : head.char_value;
                low_next   = low_unit;
                err_next   = head.is_error;
                code_next  = head.error_code;
                last_next  = !supp;
                done_next  = head.text_done;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pair_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pair_reg  <= pair_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        low_reg  <= low_next;
        err_reg  <= err_next;
        code_reg <= code_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign result_valid = valid_reg;
    assign char_value   = char_reg;
    assign is_error     = err_reg;
    assign error_code   = code_reg;
    assign last_of_run  = last_reg;
    assign text_done    = done_reg;

endmodule

`default_nettype wire

>>> src/utf8_validating_decoder.sv
// top level: streaming utf-8 validating decoder with code point or utf-16 output
// a byte that completes a sequence is queued as an event, then loads the single output register
// throughput: one byte per cycle while the queue has room; a surrogate pair is two results
// the event queue absorbs output stalls; byte_ready drops only when the queue is full
// reset: asynchronous active low, clears sequence state, queue, output stage and output_utf16
`default_nettype none

module utf8_validating_decoder #(
    parameter int QUEUE_DEPTH = utf8d_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [utf8d_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [utf8d_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [utf8d_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                  pready,
    input  wire logic [7:0]                       byte_value,
    input  wire logic                             end_of_text,
    input  wire logic                             byte_valid,
    output logic                                  byte_ready,
    output logic [20:0]                           char_value,
    output logic                                  is_error,
    output logic [2:0]                            error_code,
    output logic                                  last_of_run,
    output logic                                  text_done,
    output logic                                  result_valid,
    input  wire logic                             result_ready
);

    localparam int AW = utf8d_pkg::CFG_ADDR_W;

    logic                     utf16_reg;
    logic                     sel_utf16;
    logic                     push;
    logic                     pop;
    utf8d_pkg::queue_entry_t  push_data;
    utf8d_pkg::queue_entry_t  head;
    utf8d_pkg::queue_status_t q_status;

    assign pready    = 1'b1;
    assign sel_utf16 = (paddr[AW-1:2] == utf8d_pkg::ADDR_OUTPUT_UTF16[AW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utf16_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && sel_utf16)
        begin
            utf16_reg <= pwdata[0];
        end
    end

    assign prdata = sel_utf16 ? {{(utf8d_pkg::CFG_DATA_W-1){1'b0}}, utf16_reg} : '0;

    utf8d_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_value  (byte_value),
        .end_of_text (end_of_text),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .q_status    (q_status),
        .push        (push),
        .push_data   (push_data)
    );

    utf8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    utf8d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .output_utf16 (utf16_reg),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .char_value   (char_value),
        .is_error     (is_error),
        .error_code   (error_code),
        .last_of_run  (last_of_run),
        .text_done    (text_done)
    );

endmodule

`default_nettype wire

>>> src/utf8d_checker.sv
// port-level checks on the decoder result channel, bound to the top level
`default_nettype none

`include "utf8_validating_decoder_macros.svh"

module utf8d_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        result_valid,
    input wire logic        result_ready,
    input wire logic [20:0] char_value,
    input wire logic        is_error,
    input wire logic [2:0]  error_code,
    input wire logic        last_of_run
);

    logic error_ok;
    logic char_ok;
    logic high_ok;
    logic low_ok;

    assign error_ok = (char_value == 21'd0) && last_of_run
                   && (error_code != utf8d_pkg::ERR_NONE)
                   && (error_code <= utf8d_pkg::ERR_BAD_CODE_PT);
    assign char_ok  = (error_code == utf8d_pkg::ERR_NONE)
                   && (char_value <= utf8d_pkg::MAX_CODE_POINT);
    assign high_ok  = !is_error && (char_value >= utf8d_pkg::HIGH_SURR_BASE)
                   && (char_value < utf8d_pkg::LOW_SURR_BASE);
    assign low_ok   = last_of_run && (char_value >= utf8d_pkg::LOW_SURR_BASE)
                   && (char_value <= utf8d_pkg::SURROGATE_LAST);

    `UTF8D_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(char_value) && $stable(error_code), "result changed while stalled")

    `UTF8D_ASSERT_IMPLIES(a_error_shape, result_valid && is_error, error_ok, "malformed error result")

    `UTF8D_ASSERT_IMPLIES(a_char_code, result_valid && !is_error, char_ok, "character result with bad code")

    `UTF8D_ASSERT_IMPLIES(a_high_surrogate, result_valid && !last_of_run, high_ok, "first of pair is not a high surrogate")

    `UTF8D_ASSERT_NEXT(a_low_follows, result_valid && result_ready && !last_of_run, result_valid && low_ok, "low surrogate does not follow")

endmodule

bind utf8_validating_decoder utf8d_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .char_value   (char_value),
    .is_error     (is_error),
    .error_code   (error_code),
    .last_of_run  (last_of_run)
);

`default_nettype wire
